// ===== hw/rtl/bma_pkg.sv =====
`timescale 1ns / 1ps

package bma_pkg;

  // result codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_t;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_POOL_LOG2 = 2'd0;
  localparam logic [1:0] CFG_MIN_LOG2  = 2'd1;
  localparam logic [1:0] CFG_MAX_REQ   = 2'd2;

  // field widths
  localparam int unsigned ADDR_W = 30;
  localparam int unsigned SIZE_W = 31;
  localparam int unsigned LOG_W  = 5;

  // pool size limits (log2 of bytes)
  localparam logic [LOG_W-1:0] POOL_LOG2_MIN = 5'd10;
  localparam logic [LOG_W-1:0] POOL_LOG2_MAX = 5'd30;

  // reset values of the registers
  localparam logic [LOG_W-1:0]  POOL_LOG2_RST = 5'd20;
  localparam logic [LOG_W-1:0]  MIN_LOG2_RST  = 5'd10;
  localparam logic [SIZE_W-1:0] MAX_REQ_RST   = 31'd1073741824;

endpackage

// ===== hw/rtl/bma_ram.sv =====
`timescale 1ns / 1ps

module bma_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/buddy_memory_allocator.sv =====
`timescale 1ns / 1ps

// Binary buddy allocator over a pool of 2^pool_size_log2 bytes, kept as a
// tree of LEVELS+1 levels in one block RAM; each word holds an allocated
// flag and the height of the largest wholly free block below that node.
// One command is worked at a time and in_stall stays high meanwhile;
// configuration beats are taken only between commands. An allocate rounds
// the size up one step at a time from the minimum block, searches the
// tree in address order with climb steps, splits level by level and then
// merges back up to the root; one that is refused for size goes straight
// to the result. A free walks the tree down to the block and, when the
// address is good, merges back up to the root. A stalled result holds the
// block until it is taken. Every step goes through the single RAM read
// port. After reset, and after any write to pool_size_log2 or
// min_block_log2, a clearing pass over all 2^(LEVELS+1)-1 nodes rebuilds
// the tree before the first command is taken.
module buddy_memory_allocator #(
  parameter int unsigned LEVELS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [bma_pkg::SIZE_W-1:0]   request_size,
  input  logic [bma_pkg::ADDR_W-1:0]   block_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [bma_pkg::ADDR_W-1:0]   granted_address,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [bma_pkg::SIZE_W-1:0]   cfg_data
);

  localparam int unsigned NW    = LEVELS + 1;
  localparam int unsigned NODES = (1 << (LEVELS + 1)) - 1;
  localparam int unsigned DW    = $clog2(LEVELS + 1);
  localparam int unsigned PW    = LEVELS;
  localparam int unsigned LW    = bma_pkg::LOG_W;
  localparam int unsigned AW    = bma_pkg::ADDR_W;
  localparam logic [LW-1:0] TOP_H = LW'(LEVELS + 1);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SIZE, S_SRCH_RD, S_SRCH_EV, S_CLIMB, S_SPLIT_L,
    S_SPLIT_R, S_MARK, S_UP_RD, S_UP_EV, S_FREE_RD, S_FREE_EV, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [LW-1:0]              pool_log2;
  logic [LW-1:0]              min_log2;
  logic [bma_pkg::SIZE_W-1:0] max_req;

  // command context
  logic [bma_pkg::SIZE_W-1:0] req_q;
  logic [AW-1:0]              addr_q;
  logic [LW-1:0]              t;
  logic [LW-1:0]              td;
  logic [LW-1:0]              ht;
  logic [NW-1:0]              n;
  logic [DW-1:0]              d;
  logic [PW-1:0]              pos;
  logic                       found;
  logic [NW-1:0]              best_n;
  logic [DW-1:0]              best_d;
  logic [PW-1:0]              best_pos;
  logic [LW-1:0]              best_h;
  logic [LW-1:0]              cur_val;
  bma_pkg::status_t           st;
  logic [AW-1:0]              gaddr;

  // effective geometry
  logic [LW-1:0] p_eff;
  logic [LW-1:0] m_eff;
  logic [LW-1:0] dmax;
  logic [LW-1:0] m_raised;

  always_comb begin
    if (pool_log2 < bma_pkg::POOL_LOG2_MIN) begin
      p_eff = bma_pkg::POOL_LOG2_MIN;
    end else if (pool_log2 > bma_pkg::POOL_LOG2_MAX) begin
      p_eff = bma_pkg::POOL_LOG2_MAX;
    end else begin
      p_eff = pool_log2;
    end
    if (({1'b0, min_log2} + 6'(LEVELS)) < {1'b0, p_eff}) begin
      m_raised = p_eff - LW'(LEVELS);
    end else begin
      m_raised = min_log2;
    end
    m_eff = (m_raised > p_eff) ? p_eff : m_raised;
    dmax  = p_eff - m_eff;
  end

  // tree RAM: {allocated, largest free height}
  logic                  ram_we;
  logic [NW-1:0]         ram_waddr;
  logic [LW:0]           ram_wdata;
  logic [NW-1:0]         ram_raddr;
  logic [LW:0]           ram_rdata;
  logic                  rd_alloc;
  logic [LW-1:0]         rd_slf;

  bma_ram #(
    .WIDTH (LW + 1),
    .DEPTH (NODES)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_alloc = ram_rdata[LW];
  assign rd_slf   = ram_rdata[LW-1:0];

  // node arithmetic
  logic [LW-1:0] hd;
  logic [NW-1:0] left_n;
  logic [NW-1:0] sib_n;
  logic [NW-1:0] parent_n;
  logic [NW-1:0] depth_last;
  logic [LW-1:0] merged;
  logic [LW-1:0] sh_amt;
  logic [AW-1:0] shifted;
  logic [LW-1:0] bit_idx;
  logic          addr_bit;

  assign hd         = TOP_H - LW'(d);
  assign left_n     = {n[NW-2:0], 1'b1};
  assign sib_n      = n[0] ? (n + NW'(1)) : (n - NW'(1));
  assign parent_n   = (n - NW'(1)) >> 1;
  assign depth_last = (NW'(1) << (d + DW'(1))) - NW'(2);
  assign bit_idx    = p_eff - LW'(d) - LW'(1);
  assign addr_bit   = addr_q[bit_idx];

  always_comb begin
    if (cur_val == hd && rd_slf == hd) begin
      merged = hd + LW'(1);
    end else begin
      merged = (cur_val > rd_slf) ? cur_val : rd_slf;
    end
  end

  // shared shifter: granted address or block start
  assign sh_amt  = (state == S_MARK) ? t : (p_eff - LW'(d));
  assign shifted = AW'(pos) << sh_amt;

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n;
    ram_wdata = {1'b0, hd};
    ram_raddr = (state == S_UP_RD) ? sib_n : n;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SPLIT_L: begin
        ram_we    = (LW'(d) < td);
        ram_waddr = left_n;
        ram_wdata = {1'b0, hd - LW'(1)};
      end
      S_SPLIT_R: begin
        ram_we    = 1'b1;
        ram_waddr = left_n + NW'(1);
        ram_wdata = {1'b0, hd - LW'(1)};
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, LW'(0)};
      end
      S_UP_EV: begin
        ram_we    = 1'b1;
        ram_waddr = parent_n;
        ram_wdata = {1'b0, merged};
      end
      S_FREE_EV: begin
        ram_we = rd_alloc && (shifted == addr_q);
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      n         <= '0;
      d         <= '0;
      out_valid <= 1'b0;
      pool_log2 <= bma_pkg::POOL_LOG2_RST;
      min_log2  <= bma_pkg::MIN_LOG2_RST;
      max_req   <= bma_pkg::MAX_REQ_RST;
    end else begin
      // drop a taken result unless a new one replaces it
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            // take configuration beats; geometry writes rebuild the tree
            unique case (cfg_index)
              bma_pkg::CFG_POOL_LOG2: begin
                pool_log2 <= cfg_data[LW-1:0];
                state     <= S_CLEAR;
                n         <= '0;
                d         <= '0;
              end
              bma_pkg::CFG_MIN_LOG2: begin
                min_log2 <= cfg_data[LW-1:0];
                state    <= S_CLEAR;
                n        <= '0;
                d        <= '0;
              end
              bma_pkg::CFG_MAX_REQ: begin
                max_req <= cfg_data;
              end
              default: begin
              end
            endcase
          end else if (in_valid) begin
            req_q  <= request_size;
            addr_q <= block_address;
            gaddr  <= '0;
            n      <= '0;
            d      <= '0;
            pos    <= '0;
            found  <= 1'b0;
            if (command == bma_pkg::CMD_ALLOC) begin
              t <= m_eff;
              if (request_size > max_req) begin
                st    <= bma_pkg::ST_TOO_BIG;
                state <= S_FINISH;
              end else begin
                state <= S_SIZE;
              end
            end else begin
              st <= bma_pkg::ST_BAD_ADDR;
              if ((block_address >> p_eff) != '0) begin
                state <= S_FINISH;
              end else begin
                state <= S_FREE_RD;
              end
            end
          end
        end

        // sweep the tree back to all free
        S_CLEAR: begin
          if (n == LAST_NODE) begin
            state <= S_IDLE;
          end else begin
            n <= n + NW'(1);
            if (n == depth_last) begin
              d <= d + DW'(1);
            end
          end
        end

        // round the request up one power of two a cycle
        S_SIZE: begin
          if (t > p_eff) begin
            st    <= bma_pkg::ST_NO_MEM;
            state <= S_FINISH;
          end else if ((32'(1) << t) < {1'b0, req_q}) begin
            t <= t + LW'(1);
          end else begin
            td    <= p_eff - t;
            ht    <= TOP_H - (p_eff - t);
            state <= S_SRCH_RD;
          end
        end

        S_SRCH_RD: begin
          state <= S_SRCH_EV;
        end

        // address-order walk for the smallest fitting free block
        S_SRCH_EV: begin
          if (rd_alloc || rd_slf < ht) begin
            state <= S_CLIMB;
          end else if (rd_slf == hd) begin
            if (hd == ht) begin
              state <= S_SPLIT_L;
            end else begin
              if (!found || hd < best_h) begin
                found    <= 1'b1;
                best_n   <= n;
                best_d   <= d;
                best_pos <= pos;
                best_h   <= hd;
              end
              state <= S_CLIMB;
            end
          end else begin
            n     <= left_n;
            d     <= d + DW'(1);
            pos   <= pos << 1;
            state <= S_SRCH_RD;
          end
        end

        S_CLIMB: begin
          if (n == '0) begin
            if (found) begin
              n     <= best_n;
              d     <= best_d;
              pos   <= best_pos;
              state <= S_SPLIT_L;
            end else begin
              st    <= bma_pkg::ST_NO_MEM;
              state <= S_FINISH;
            end
          end else if (!n[0]) begin
            n   <= parent_n;
            d   <= d - DW'(1);
            pos <= pos >> 1;
          end else begin
            n     <= n + NW'(1);
            pos   <= pos + PW'(1);
            state <= S_SRCH_RD;
          end
        end

        // halve the block down to the wanted size
        S_SPLIT_L: begin
          if (LW'(d) < td) begin
            state <= S_SPLIT_R;
          end else begin
            state <= S_MARK;
          end
        end

        S_SPLIT_R: begin
          n     <= left_n;
          d     <= d + DW'(1);
          pos   <= pos << 1;
          state <= S_SPLIT_L;
        end

        S_MARK: begin
          cur_val <= '0;
          gaddr   <= shifted;
          state   <= S_UP_RD;
        end

        // merge back toward the root
        S_UP_RD: begin
          if (d == '0) begin
            st    <= bma_pkg::ST_OK;
            state <= S_FINISH;
          end else begin
            state <= S_UP_EV;
          end
        end

        S_UP_EV: begin
          cur_val <= merged;
          n       <= parent_n;
          d       <= d - DW'(1);
          pos     <= pos >> 1;
          state   <= S_UP_RD;
        end

        S_FREE_RD: begin
          state <= S_FREE_EV;
        end

        // follow the address down to the allocated block
        S_FREE_EV: begin
          if (rd_alloc) begin
            if (shifted == addr_q) begin
              cur_val <= hd;
              state   <= S_UP_RD;
            end else begin
              state <= S_FINISH;
            end
          end else if (rd_slf == hd || LW'(d) >= dmax) begin
            state <= S_FINISH;
          end else begin
            n     <= left_n + NW'(addr_bit);
            d     <= d + DW'(1);
            pos   <= (pos << 1) | PW'(addr_bit);
            state <= S_FREE_RD;
          end
        end

        // hold until the result register is free
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= st;
            granted_address <= (st == bma_pkg::ST_OK) ? gaddr : '0;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bma_checker.sv =====
`timescale 1ns / 1ps

module bma_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic [bma_pkg::ADDR_W-1:0] granted_address
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_address))
    else $error("result changed while stalled");

  // only a good allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bma_pkg::ST_OK |-> granted_address == '0)
    else $error("address on a failed result");

  // a taken command keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // the tree is rebuilt after reset
  a_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block ready right after reset");

endmodule

bind buddy_memory_allocator bma_checker u_bma_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .granted_address (granted_address)
);

// ===== tb/sv/buddy_memory_allocator_test.sv =====
`timescale 1ns / 1ps

module buddy_memory_allocator_test;

  localparam int unsigned LV    = 10;
  localparam int unsigned NODES = (1 << (LV + 1)) - 1;
  localparam int unsigned HOLD  = 400;

  typedef struct packed {
    bma_pkg::status_t           st;
    logic [bma_pkg::ADDR_W-1:0] addr;
  } grant_t;

  // Tracks the block tree and the outcomes it implies, in acceptance order
  class buddy_ledger;
    byte unsigned largest[NODES];
    bit           taken[NODES];
    logic [bma_pkg::LOG_W-1:0]  pool_reg;
    logic [bma_pkg::LOG_W-1:0]  min_reg;
    logic [bma_pkg::SIZE_W-1:0] max_req;
    grant_t pending[$];
    int errors, mismatches;
    int n_granted, n_freed, n_too_big, n_no_mem, n_bad_addr;

    function int unsigned ht(int unsigned d);
      return LV + 1 - d;
    endfunction

    function int unsigned first(int unsigned d);
      return (1 << d) - 1;
    endfunction

    function void rebuild();
      for (int unsigned d = 0; d <= LV; d++)
        for (int unsigned n = first(d); n < first(d + 1); n++) begin
          largest[n] = ht(d);
          taken[n] = 0;
        end
    endfunction

    function void power_up();
      pool_reg = bma_pkg::POOL_LOG2_RST;
      min_reg = bma_pkg::MIN_LOG2_RST;
      max_req = bma_pkg::MAX_REQ_RST;
      rebuild();
    endfunction

    function int unsigned pool_log2();
      int unsigned p;
      p = pool_reg;
      if (p < 10) p = 10;
      if (p > 30) p = 30;
      return p;
    endfunction

    function int unsigned min_log2();
      int unsigned p, m;
      p = pool_log2();
      m = min_reg;
      if (m + LV < p) m = p - LV;
      if (m > p) m = p;
      return m;
    endfunction

    function void write_reg(logic [1:0] idx, logic [bma_pkg::SIZE_W-1:0] data);
      case (idx)
        bma_pkg::CFG_POOL_LOG2: begin
          pool_reg = data[bma_pkg::LOG_W-1:0];
          rebuild();
        end
        bma_pkg::CFG_MIN_LOG2: begin
          min_reg = data[bma_pkg::LOG_W-1:0];
          rebuild();
        end
        bma_pkg::CFG_MAX_REQ: max_req = data;
        default: ;
      endcase
    endfunction

    // merge back up toward the root
    function void climb(int unsigned n, int unsigned d);
      int unsigned par, l, hc;
      while (d > 0) begin
        par = (n - 1) / 2;
        l = 2 * par + 1;
        hc = ht(d);
        if (largest[l] == hc && largest[l + 1] == hc) largest[par] = ht(d - 1);
        else largest[par] = largest[l] > largest[l + 1] ? largest[l] : largest[l + 1];
        n = par;
        d--;
      end
    endfunction

    function bit free_top(int unsigned n, int unsigned d);
      if (largest[n] != ht(d)) return 0;
      while (n > 0) begin
        n = (n - 1) / 2;
        d--;
        if (taken[n] || largest[n] == ht(d)) return 0;
      end
      return 1;
    endfunction

    function grant_t run_alloc(logic [bma_pkg::SIZE_W-1:0] size);
      grant_t g;
      int unsigned p, m, t, td, found, fd, cur, d;
      bit ok;
      longint unsigned r;
      p = pool_log2();
      m = min_log2();
      g.st = bma_pkg::ST_OK;
      g.addr = '0;
      r = size;
      if (size > max_req) begin
        g.st = bma_pkg::ST_TOO_BIG;
        return g;
      end
      t = 0;
      while (t < 32 && (64'd1 << t) < r) t++;
      if (t < m) t = m;
      if (t > p) begin
        g.st = bma_pkg::ST_NO_MEM;
        return g;
      end
      td = p - t;
      ok = 0;
      found = 0;
      fd = 0;
      for (int lv = td; lv >= 0 && !ok; lv--)
        for (int unsigned n = first(lv); n < first(lv + 1); n++)
          if (free_top(n, lv)) begin
            found = n;
            fd = lv;
            ok = 1;
            break;
          end
      if (!ok) begin
        g.st = bma_pkg::ST_NO_MEM;
        return g;
      end
      // split down to the wanted size
      cur = found;
      d = fd;
      while (d < td) begin
        taken[cur] = 0;
        largest[2 * cur + 1] = ht(d + 1);
        largest[2 * cur + 2] = ht(d + 1);
        taken[2 * cur + 1] = 0;
        taken[2 * cur + 2] = 0;
        cur = 2 * cur + 1;
        d++;
      end
      taken[cur] = 1;
      largest[cur] = 0;
      climb(cur, d);
      g.addr = bma_pkg::ADDR_W'(longint'(cur - first(td)) << (p - td));
      return g;
    endfunction

    function grant_t run_free(logic [bma_pkg::ADDR_W-1:0] addr);
      grant_t g;
      int unsigned p, dmax, n, d;
      longint unsigned a, start;
      p = pool_log2();
      dmax = p - min_log2();
      a = addr;
      g.st = bma_pkg::ST_BAD_ADDR;
      g.addr = '0;
      if ((a >> p) != 0) return g;
      n = 0;
      d = 0;
      forever begin
        if (taken[n]) begin
          start = longint'(n - first(d)) << (p - d);
          if (start == a) begin
            taken[n] = 0;
            largest[n] = ht(d);
            climb(n, d);
            g.st = bma_pkg::ST_OK;
          end
          break;
        end
        if (largest[n] == ht(d) || d >= dmax) break;
        n = 2 * n + 1 + int'((a >> (p - d - 1)) & 1);
        d++;
      end
      return g;
    endfunction

    // note an accepted request and queue its outcome
    function grant_t note(logic cmd, logic [bma_pkg::SIZE_W-1:0] size,
                          logic [bma_pkg::ADDR_W-1:0] addr);
      grant_t g;
      g = (cmd == bma_pkg::CMD_ALLOC) ? run_alloc(size) : run_free(addr);
      case (g.st)
        bma_pkg::ST_OK:
          if (cmd == bma_pkg::CMD_ALLOC) n_granted++; else n_freed++;
        bma_pkg::ST_TOO_BIG: n_too_big++;
        bma_pkg::ST_NO_MEM:  n_no_mem++;
        default:             n_bad_addr++;
      endcase
      pending.insert(pending.size(), g);
      return g;
    endfunction

    // compare a result beat against the oldest outcome
    function void check(logic [1:0] st, logic [bma_pkg::ADDR_W-1:0] addr);
      grant_t g;
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result beat: status %0d addr 0x%08h", st, addr);
        return;
      end
      g = pending.pop_front();
      if (st !== g.st || addr !== g.addr) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, addr exp 0x%08h got 0x%08h",
                   g.st, st, g.addr, addr);
      end
    endfunction
  endclass

  logic                          clk = 0;
  logic                          rst = 1;
  logic                          in_valid = 0;
  logic                          in_stall;
  logic                          command = bma_pkg::CMD_ALLOC;
  logic [bma_pkg::SIZE_W-1:0]    request_size = '0;
  logic [bma_pkg::ADDR_W-1:0]    block_address = '0;
  logic                          out_valid;
  logic                          out_stall = 0;
  logic [1:0]                    status;
  logic [bma_pkg::ADDR_W-1:0]    granted_address;
  logic                          cfg_valid = 0;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index = bma_pkg::CFG_POOL_LOG2;
  logic [bma_pkg::SIZE_W-1:0]    cfg_data = '0;

  buddy_ledger sb = new;
  logic [bma_pkg::ADDR_W-1:0] live[$];
  bit calm = 0;
  bit hold_go = 0;

  buddy_memory_allocator #(.LEVELS(LV)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stall bursts, one long hold on request
  initial begin
    int unsigned n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      n = hold_go ? HOLD : pick_gap();
      hold_go = 0;
      out_stall <= (n > 0);
      repeat ((n > 0 ? n : $urandom_range(1, 6)) - 1) @(posedge clk);
    end
  end

  // check every accepted result beat
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check(status, granted_address);

  task automatic send(logic cmd, logic [bma_pkg::SIZE_W-1:0] size,
                      logic [bma_pkg::ADDR_W-1:0] addr);
    int unsigned gap;
    grant_t g;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    request_size <= size;
    block_address <= addr;
    do @(posedge clk); while (in_stall);
    g = sb.note(cmd, size, addr);
    if (g.st == bma_pkg::ST_OK) begin
      if (cmd == bma_pkg::CMD_ALLOC) live.insert(live.size(), g.addr);
      else
        foreach (live[i])
          if (live[i] == addr) begin
            live.delete(i);
            break;
          end
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [bma_pkg::SIZE_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned pl, int unsigned ml,
                              logic [bma_pkg::SIZE_W-1:0] mr);
    drain();
    write_reg(bma_pkg::CFG_POOL_LOG2, bma_pkg::SIZE_W'(pl));
    write_reg(bma_pkg::CFG_MIN_LOG2, bma_pkg::SIZE_W'(ml));
    write_reg(bma_pkg::CFG_MAX_REQ, mr);
    live.delete();
  endtask

  task automatic random_op();
    int unsigned p, m, k, r, i;
    logic [bma_pkg::ADDR_W-1:0] a;
    p = sb.pool_log2();
    m = sb.min_log2();
    r = $urandom_range(0, 99);
    if (live.size() != 0 && r < 45) begin
      i = $urandom_range(0, live.size() - 1);
      send(bma_pkg::CMD_FREE, bma_pkg::SIZE_W'($urandom), live[i]);
    end else if (r < 52) begin
      // free of an arbitrary in-pool address
      a = bma_pkg::ADDR_W'($urandom & ((64'd1 << p) - 1));
      if ($urandom_range(0, 1)) a = a & ~bma_pkg::ADDR_W'((64'd1 << m) - 1);
      send(bma_pkg::CMD_FREE, bma_pkg::SIZE_W'($urandom), a);
    end else if (r < 56) begin
      send(bma_pkg::CMD_FREE, bma_pkg::SIZE_W'($urandom), bma_pkg::ADDR_W'($urandom));
    end else if (r < 60) begin
      send(bma_pkg::CMD_ALLOC, bma_pkg::SIZE_W'($urandom), bma_pkg::ADDR_W'($urandom));
    end else if (r < 63) begin
      send(bma_pkg::CMD_ALLOC, '0, bma_pkg::ADDR_W'($urandom));
    end else begin
      k = m + $urandom_range(0, (p - m) / 2 + $urandom_range(0, (p - m + 1) / 2));
      if (k > 30) k = 30;
      send(bma_pkg::CMD_ALLOC,
           bma_pkg::SIZE_W'($urandom_range(1 << k, k == 0 ? 1 : (1 << (k - 1)) + 1)),
           bma_pkg::ADDR_W'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned n, bit squeeze);
    for (int unsigned i = 0; i < n; i++) begin
      if (squeeze && i == 60) hold_go = 1;
      if (i == n / 2) drain();
      random_op();
    end
  endtask

  initial begin
    sb.power_up();
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: reset geometry, 1 KiB minimum in a 1 MiB pool
    send(bma_pkg::CMD_ALLOC, '0, '0);
    send(bma_pkg::CMD_ALLOC, 31'd1, '1);
    send(bma_pkg::CMD_ALLOC, 31'd1024, '0);
    send(bma_pkg::CMD_ALLOC, 31'd1025, '0);
    send(bma_pkg::CMD_ALLOC, 31'd262144, '0);
    send(bma_pkg::CMD_ALLOC, 31'd1073741824, '0);
    send(bma_pkg::CMD_ALLOC, 31'h7FFF_FFFF, '0);
    send(bma_pkg::CMD_ALLOC, 31'd1048576, '0);
    send(bma_pkg::CMD_FREE, '1, 30'd1048576);
    send(bma_pkg::CMD_FREE, '0, 30'd100);
    send(bma_pkg::CMD_FREE, '0, 30'd524288);
    send(bma_pkg::CMD_FREE, '0, '1);
    send(bma_pkg::CMD_FREE, '0, 30'd1024);
    send(bma_pkg::CMD_FREE, '0, 30'd1024);
    while (live.size() != 0) send(bma_pkg::CMD_FREE, '0, live[0]);
    send(bma_pkg::CMD_ALLOC, 31'd1048576, '0);
    send(bma_pkg::CMD_FREE, '0, '0);
    calm = 1;
    random_phase(100, 0);
    calm = 0;

    set_geometry(10, 0, 31'd1073741824);
    random_phase(160, 0);
    set_geometry(30, 30, 31'h7FFF_FFFF);
    random_phase(120, 0);
    set_geometry(12, 5, 31'd100);
    random_phase(160, 0);
    set_geometry(5, 31, 31'd1);
    random_phase(100, 0);
    set_geometry(31, 22, 31'd1073741824);
    random_phase(180, 1);
    set_geometry(16, 6, 31'd0);
    random_phase(100, 0);
    set_geometry(24, 14, 31'd3000);
    random_phase(300, 0);

    drain();
    repeat (100) @(posedge clk);
    $display("allocs granted %0d, frees done %0d; refused: too big %0d, no memory %0d,",
             sb.n_granted, sb.n_freed, sb.n_too_big, sb.n_no_mem);
    $display("bad address %0d, over eight pool geometries", sb.n_bad_addr);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("buddy_memory_allocator_test: done, clean");
    end else begin
      $display("buddy_memory_allocator_test: done, errors");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #1_000_000_000;
    $display("buddy_memory_allocator_test: done, errors");
    $finish;
  end

endmodule
